// ----- rtl/core/prsp_pkg.sv -----
// Shared widths, register codes and pipeline payload types for the point rotate and slab block.
`default_nettype none

package prsp_pkg;

  localparam int SLICE_WIDTH_DEF  = 106;
  localparam int SLICE_HEIGHT_DEF = 120;

  localparam int POS_W      = 16;
  localparam int COLOR_W    = 8;
  localparam int Q8_W       = 10;
  localparam int Q8_SHIFT   = 8;
  localparam int PROD_W     = POS_W + Q8_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int ROT_W      = SUM_W - Q8_SHIFT;
  localparam int SX_W       = ROT_W + 1;
  localparam int SY_W       = POS_W + 2;
  localparam int PIX_W      = 10;
  localparam int HALF_W     = 16;
  localparam int STRIDE_W   = 13;
  localparam int ORIG_W     = 11;
  localparam int ROWP_W     = ORIG_W + 1;
  localparam int OFS_W      = 25;
  localparam int PIX_BYTES  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CORNER_W   = 2;

  localparam logic [Q8_W-1:0] COS_RESET = Q8_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS,
    REG_SIN,
    REG_SLAB_EN,
    REG_HALF,
    REG_STRIDE,
    REG_COL,
    REG_ROW
  } cfg_reg_t;

  typedef struct packed {
    logic [Q8_W-1:0]     cos_q8;
    logic [Q8_W-1:0]     sin_q8;
    logic                slab_enable;
    logic [HALF_W-1:0]   slab_half_thickness;
    logic [STRIDE_W-1:0] line_stride_bytes;
    logic [ORIG_W-1:0]   origin_column;
    logic [ORIG_W-1:0]   origin_row;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               final_point;
  } attr_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    attr_t            attr;
  } point_t;

  typedef struct packed {
    logic [ROT_W-1:0] rx;
    logic [ROT_W-1:0] rz;
    logic [POS_W-1:0] pos_y;
    attr_t            attr;
  } rot_t;

  typedef struct packed {
    logic             accept;
    logic             x_ok;
    logic             y_ok;
    logic [OFS_W-1:0] base;
    attr_t            attr;
  } splat_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_rotate_slab_project.sv -----
// Top level of the point rotate, slab clip and 2x2 splat projection block.
`default_nettype none

// Channel  Direction  Handshake             Payload
// cfg      in         cfg_wr_en             cfg_index (register number), cfg_data (16 bits)
// in       in         in_valid / in_ready   pos_x, pos_y, pos_z, red, green, blue, final_point
// out      out        out_valid / out_ready write_valid, byte_offset, byte0..2, corner_last,
//                                           model_last
//
// Every point request produces four corner requests, one per cycle on the result
// port while the result side does not stall; the single result port and the corner
// sequencer set the sustained point rate. From acceptance to the first corner a
// point passes two rotation stages, two clip and offset stages, the
// corner holder and the output register. Reset is synchronous and active low; it
// empties the pipeline and loads the register defaults. A stall on the result side
// backs up stage by stage, and empty stages keep taking requests meanwhile.

module point_rotate_slab_project
  import prsp_pkg::*;
#(
  parameter int SLICE_WIDTH  = SLICE_WIDTH_DEF,
  parameter int SLICE_HEIGHT = SLICE_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [POS_W-1:0]      in_pos_x,
  input  wire logic [POS_W-1:0]      in_pos_y,
  input  wire logic [POS_W-1:0]      in_pos_z,
  input  wire logic [COLOR_W-1:0]    in_red,
  input  wire logic [COLOR_W-1:0]    in_green,
  input  wire logic [COLOR_W-1:0]    in_blue,
  input  wire logic                  in_final_point,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_write_valid,
  output logic [OFS_W-1:0]           out_byte_offset,
  output logic [COLOR_W-1:0]         out_byte0_green,
  output logic [COLOR_W-1:0]         out_byte1_blue,
  output logic [COLOR_W-1:0]         out_byte2_red,
  output logic                       out_corner_last,
  output logic                       out_model_last
);

  // Configuration registers. Writes must arrive only while the pipeline is empty,
  // which the block itself does not enforce; every stage reads them directly.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS:     cfg_nxt.cos_q8              = cfg_data[Q8_W-1:0];
        REG_SIN:     cfg_nxt.sin_q8              = cfg_data[Q8_W-1:0];
        REG_SLAB_EN: cfg_nxt.slab_enable         = cfg_data[0];
        REG_HALF:    cfg_nxt.slab_half_thickness = cfg_data[HALF_W-1:0];
        REG_STRIDE:  cfg_nxt.line_stride_bytes   = cfg_data[STRIDE_W-1:0];
        REG_COL:     cfg_nxt.origin_column       = cfg_data[ORIG_W-1:0];
        REG_ROW:     cfg_nxt.origin_row          = cfg_data[ORIG_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_q8              <= COS_RESET;
      cfg_r.sin_q8              <= '0;
      cfg_r.slab_enable         <= 1'b0;
      cfg_r.slab_half_thickness <= '0;
      cfg_r.line_stride_bytes   <= '0;
      cfg_r.origin_column       <= '0;
      cfg_r.origin_row          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  point_t in_point;
  rot_t   rot_data;
  splat_t splat_data;
  logic   rot_valid, rot_ready, splat_valid, splat_ready;

  always_comb begin
    in_point.pos_x            = in_pos_x;
    in_point.pos_y            = in_pos_y;
    in_point.pos_z            = in_pos_z;
    in_point.attr.red         = in_red;
    in_point.attr.green       = in_green;
    in_point.attr.blue        = in_blue;
    in_point.attr.final_point = in_final_point;
  end

  // Stages one and two: products, then rotated x and depth.
  prsp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_point),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  // Stages three and four: slab and slice tests, then the anchor's byte offset.
  prsp_clip #(
    .SLICE_WIDTH  (SLICE_WIDTH),
    .SLICE_HEIGHT (SLICE_HEIGHT)
  ) u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot_data),
    .out_valid (splat_valid),
    .out_ready (splat_ready),
    .out_data  (splat_data)
  );

  // The corner sequencer fans each splat out into four result requests.
  prsp_corner u_corner (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (splat_valid),
    .in_ready        (splat_ready),
    .in_data         (splat_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_valid (out_write_valid),
    .out_byte_offset (out_byte_offset),
    .out_byte0_green (out_byte0_green),
    .out_byte1_blue  (out_byte1_blue),
    .out_byte2_red   (out_byte2_red),
    .out_corner_last (out_corner_last),
    .out_model_last  (out_model_last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/prsp_rotate.sv -----
// Two-stage Y-axis rotation: four Q8 products, then the sums shifted down by eight.
`default_nettype none

module prsp_rotate
  import prsp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire point_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rot_t        out_data
);

  typedef struct packed {
    logic [PROD_W-1:0] p_xc;
    logic [PROD_W-1:0] p_zs;
    logic [PROD_W-1:0] p_zc;
    logic [PROD_W-1:0] p_xs;
    logic [POS_W-1:0]  pos_y;
    attr_t             attr;
  } prod_t;

  logic  s1_v_r, s2_v_r;
  logic  s1_en, s2_en;
  prod_t s1_r, s1_nxt;
  rot_t  s2_r, s2_nxt;
  logic signed [SUM_W-1:0] sum_x, sum_z;

  assign s2_en    = !s2_v_r || out_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  always_comb begin
    s1_nxt.p_xc  = PROD_W'($signed(in_data.pos_x) * $signed(cfg.cos_q8));
    s1_nxt.p_zs  = PROD_W'($signed(in_data.pos_z) * $signed(cfg.sin_q8));
    s1_nxt.p_zc  = PROD_W'($signed(in_data.pos_z) * $signed(cfg.cos_q8));
    s1_nxt.p_xs  = PROD_W'($signed(in_data.pos_x) * $signed(cfg.sin_q8));
    s1_nxt.pos_y = in_data.pos_y;
    s1_nxt.attr  = in_data.attr;
  end

  // Floor division by 256 is the arithmetic shift, taken as a part-select.
  assign sum_x = {s1_r.p_xc[PROD_W-1], s1_r.p_xc} + {s1_r.p_zs[PROD_W-1], s1_r.p_zs};
  assign sum_z = {s1_r.p_zc[PROD_W-1], s1_r.p_zc} - {s1_r.p_xs[PROD_W-1], s1_r.p_xs};

  always_comb begin
    s2_nxt.rx    = sum_x[SUM_W-1:Q8_SHIFT];
    s2_nxt.rz    = sum_z[SUM_W-1:Q8_SHIFT];
    s2_nxt.pos_y = s1_r.pos_y;
    s2_nxt.attr  = s1_r.attr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_en && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

endmodule

`default_nettype wire

// ----- rtl/core/prsp_clip.sv -----
// Two-stage slab and slice test followed by the framebuffer offset of the top-left corner.
`default_nettype none

module prsp_clip
  import prsp_pkg::*;
#(
  parameter int SLICE_WIDTH  = SLICE_WIDTH_DEF,
  parameter int SLICE_HEIGHT = SLICE_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire rot_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output splat_t    out_data
);

  localparam logic signed [SX_W-1:0] CENTER_X = SX_W'(SLICE_WIDTH / 2);
  localparam logic signed [SY_W-1:0] CENTER_Y = SY_W'(SLICE_HEIGHT / 2);
  localparam logic signed [SX_W-1:0] LIMIT_X  = SX_W'(SLICE_WIDTH);
  localparam logic signed [SY_W-1:0] LIMIT_Y  = SY_W'(SLICE_HEIGHT);
  localparam logic signed [SX_W-1:0] EDGE_X   = SX_W'(SLICE_WIDTH - 1);
  localparam logic signed [SY_W-1:0] EDGE_Y   = SY_W'(SLICE_HEIGHT - 1);

  typedef struct packed {
    logic              accept;
    logic              x_ok;
    logic              y_ok;
    logic [ROWP_W-1:0] rowp;
    logic [ROWP_W-1:0] colp;
    attr_t             attr;
  } anchor_t;

  logic    s3_v_r, s4_v_r;
  logic    s3_en, s4_en;
  anchor_t s3_r, s3_nxt;
  splat_t  s4_r, s4_nxt;

  logic signed [SX_W-1:0] sx, rz_e, half_e;
  logic signed [SY_W-1:0] sy;
  logic                   in_slab;
  logic [OFS_W-1:0]       row_term, col_term;

  assign s4_en    = !s4_v_r || out_ready;
  assign s3_en    = !s3_v_r || s4_en;
  assign in_ready = s3_en;

  assign sx     = CENTER_X + {in_data.rx[ROT_W-1], in_data.rx};
  assign sy     = CENTER_Y - {{(SY_W-POS_W){in_data.pos_y[POS_W-1]}}, in_data.pos_y};
  assign rz_e   = {in_data.rz[ROT_W-1], in_data.rz};
  assign half_e = {{(SX_W-HALF_W){1'b0}}, cfg.slab_half_thickness};

  assign in_slab = !cfg.slab_enable || ((rz_e <= half_e) && (rz_e >= -half_e));

  always_comb begin
    s3_nxt.accept = in_slab && !sx[SX_W-1] && (sx < LIMIT_X) && !sy[SY_W-1] && (sy < LIMIT_Y);
    s3_nxt.x_ok   = sx < EDGE_X;
    s3_nxt.y_ok   = sy < EDGE_Y;
    s3_nxt.rowp   = {1'b0, cfg.origin_row} + ROWP_W'(sy[PIX_W-1:0]);
    s3_nxt.colp   = {1'b0, cfg.origin_column} + ROWP_W'(sx[PIX_W-1:0]);
    s3_nxt.attr   = in_data.attr;
  end

  // Offsets wrap at 25 bits, so both terms are formed modulo that width.
  assign row_term = OFS_W'(s3_r.rowp) * OFS_W'(cfg.line_stride_bytes);
  assign col_term = OFS_W'(s3_r.colp) * OFS_W'(PIX_BYTES);

  always_comb begin
    s4_nxt.accept = s3_r.accept;
    s4_nxt.x_ok   = s3_r.x_ok;
    s4_nxt.y_ok   = s3_r.y_ok;
    s4_nxt.base   = row_term + col_term;
    s4_nxt.attr   = s3_r.attr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_v_r <= in_valid;
      end
      if (s4_en) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && in_valid) begin
      s3_r <= s3_nxt;
    end
    if (s4_en && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_r;

endmodule

`default_nettype wire

// ----- rtl/core/prsp_corner.sv -----
// Corner sequencer: holds one splat and issues its four corner requests through an output register.
`default_nettype none

module prsp_corner
  import prsp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire splat_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        out_write_valid,
  output logic [OFS_W-1:0]   out_byte_offset,
  output logic [COLOR_W-1:0] out_byte0_green,
  output logic [COLOR_W-1:0] out_byte1_blue,
  output logic [COLOR_W-1:0] out_byte2_red,
  output logic        out_corner_last,
  output logic        out_model_last
);

  localparam logic [CORNER_W-1:0] LAST_CORNER = '1;

  logic                ser_v_r;
  splat_t              ser_r;
  logic [CORNER_W-1:0] cnt_r, cnt_nxt;
  logic                ov_r;
  logic                load, take, last;
  logic                dx, dy, wv;
  logic [OFS_W-1:0]    ofs_nxt;

  logic               wv_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [COLOR_W-1:0] g_r, b_r, red_r;
  logic               cl_r, ml_r;

  assign load     = ser_v_r && (!ov_r || out_ready);
  assign last     = cnt_r == LAST_CORNER;
  assign take     = !ser_v_r || (load && last);
  assign in_ready = take;
  assign cnt_nxt  = cnt_r + CORNER_W'(1);

  // Corner order is left-top, right-top, left-bottom, right-bottom.
  assign dx = cnt_r[0];
  assign dy = cnt_r[1];
  assign wv = ser_r.accept && (!dx || ser_r.x_ok) && (!dy || ser_r.y_ok);
  assign ofs_nxt = ser_r.base + (dx ? OFS_W'(PIX_BYTES) : '0)
                 + (dy ? OFS_W'(cfg.line_stride_bytes) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (take) begin
        ser_v_r <= in_valid;
        cnt_r   <= '0;
      end else if (load) begin
        cnt_r <= cnt_nxt;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      ser_r <= in_data;
    end
    if (load) begin
      wv_r  <= wv;
      ofs_r <= wv ? ofs_nxt : '0;
      g_r   <= wv ? ser_r.attr.green : '0;
      b_r   <= wv ? ser_r.attr.blue : '0;
      red_r <= wv ? ser_r.attr.red : '0;
      cl_r  <= last;
      ml_r  <= last && ser_r.attr.final_point;
    end
  end

  assign out_valid       = ov_r;
  assign out_write_valid = wv_r;
  assign out_byte_offset = ofs_r;
  assign out_byte0_green = g_r;
  assign out_byte1_blue  = b_r;
  assign out_byte2_red   = red_r;
  assign out_corner_last = cl_r;
  assign out_model_last  = ml_r;

  a_model_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_model_last |-> out_corner_last)
    else $error("model_last set on a corner other than the fourth");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    load && last && !in_valid |=> !ser_v_r)
    else $error("splat holder still busy after its fourth corner");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    load && !last |=> ser_v_r && (cnt_r == $past(cnt_nxt)))
    else $error("corner counter skipped or lost its splat");

  a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> (out_byte_offset == '0) && (out_byte2_red == '0))
    else $error("undrawn corner carries payload");

endmodule

`default_nettype wire
